>>> rtl/golay_24_12_error_trap_decoder_unit_macros.svh
// Assertion macros for the Golay (24,12) error trapping decoder checker.
`ifndef GOLAY_24_12_ERROR_TRAP_DECODER_UNIT_MACROS_SVH
`define GOLAY_24_12_ERROR_TRAP_DECODER_UNIT_MACROS_SVH

// Same-cycle implication, checked on clk with reset masking.
`define G24_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("g24 check failed");

// Next-cycle implication.
`define G24_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("g24 check failed");

`endif

>>> rtl/g24_pkg.sv
// Shared types and constants for the Golay (24,12) error trapping decoder.
package g24_pkg;

  localparam int unsigned SynW  = 11;
  localparam int unsigned WordW = 23;
  localparam int unsigned CntW  = 5;

  localparam logic [SynW-1:0] GEN_LOW = 11'h475;
  localparam logic [SynW-1:0] Q16_SYN = 11'h366;
  localparam logic [SynW-1:0] Q17_SYN = 11'h6CC;

  // last bit index / last trial index
  localparam logic [CntW-1:0] CNT_LAST = 5'd22;

  // bit positions flipped in the rotated frame for the two information traps
  localparam int unsigned FLIP16_POS = 6;
  localparam int unsigned FLIP17_POS = 5;
  // pattern bits land at positions PAT_BASE .. PAT_BASE+10 (reversed)
  localparam int unsigned PAT_BASE   = 12;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_TRAP,
    ST_HOLD
  } g24_state_t;

  typedef struct packed {
    logic            hit;
    logic            flip16;
    logic            flip17;
    logic [SynW-1:0] pat;
  } g24_trap_t;

  function automatic logic [3:0] weight11(input logic [SynW-1:0] v);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < SynW; i++) begin
      n = n + {3'b000, v[i]};
    end
    return n;
  endfunction

endpackage

>>> rtl/g24_syn_unit.sv
// Shared syndrome step and trap test: one divider shift and three weight checks.
module g24_syn_unit
  import g24_pkg::*;
(
  input  logic [SynW-1:0] syn,
  input  logic            bit_in,
  output logic [SynW-1:0] syn_nxt,
  output g24_trap_t       trap
);

  logic [SynW-1:0] x16;
  logic [SynW-1:0] x17;

  assign syn_nxt = {syn[SynW-2:0], bit_in} ^ (syn[SynW-1] ? GEN_LOW : '0);
  assign x16 = syn ^ Q16_SYN;
  assign x17 = syn ^ Q17_SYN;

  always_comb begin
    trap = '0;
    priority if (weight11(syn) <= 4'd3) begin
      trap.hit = 1'b1;
      trap.pat = syn;
    end else if (weight11(x16) <= 4'd2) begin
      trap.hit    = 1'b1;
      trap.flip16 = 1'b1;
      trap.pat    = x16;
    end else if (weight11(x17) <= 4'd2) begin
      trap.hit    = 1'b1;
      trap.flip17 = 1'b1;
      trap.pat    = x17;
    end else begin
      // no trap at this rotation
      trap.hit = 1'b0;
    end
  end

endmodule

>>> rtl/golay_24_12_error_trap_decoder_unit.sv
// Top level: extended Golay (24,12) decoder by Kasami error trapping.
//
// Input channel: in_valid / in_stall carry one 24-bit received word per beat.
// Bit 0 is the first bit on the air; bit 23 is ignored.
// Output channel: out_valid / out_stall carry one 24-bit decoded word per
// beat: bits 0..22 corrected, bit 23 the recomputed overall parity.
//
// Each word passes from accept to result through a load step, syndrome
// division (one received bit per cycle through the shared divider/trap
// unit), the trap phase, and a final step that loads the output register.
// The trap phase always runs all 23 rotations: the word is rotated
// alongside the syndrome, so a trapped pattern is applied at fixed positions
// and the 23rd rotation brings the word back into input order.
// in_stall is high from accept until the result enters the output register,
// so the decoder takes no new word before it is through with the last one.
// A stalled result holds in the output register; the decoder waits in its
// final state until the register frees, without dropping anything.
// Reset (rst_n low, synchronous) empties the output register and returns
// the sequencer to idle; no clearing pass is needed.
module golay_24_12_error_trap_decoder_unit
  import g24_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [23:0] in_received_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [23:0] out_decoded_word
);

  g24_state_t       state_r, state_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic [WordW-1:0] word_r, word_nxt;
  logic [SynW-1:0]  syn_r, syn_nxt;
  logic             found_r, found_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [23:0]      out_word_r, out_word_nxt;

  logic [SynW-1:0]  unit_syn;
  logic             unit_bit;
  g24_trap_t        trap;
  logic [WordW-1:0] corr;
  logic [WordW-1:0] fixed;
  logic             slot_free;

  // shared divider: fed word bits while dividing, zeros while trapping
  assign unit_bit = (state_r == ST_SHIFT) ? word_r[cnt_r] : 1'b0;

  g24_syn_unit u_syn (
    .syn     (syn_r),
    .bit_in  (unit_bit),
    .syn_nxt (unit_syn),
    .trap    (trap)
  );

  // error pattern in the rotated frame
  always_comb begin
    corr = '0;
    for (int t = 0; t < SynW; t++) begin
      corr[PAT_BASE+t] = trap.pat[SynW-1-t];
    end
    corr[FLIP16_POS] = trap.flip16;
    corr[FLIP17_POS] = trap.flip17;
  end

  assign fixed     = (!found_r && trap.hit) ? (word_r ^ corr) : word_r;
  assign slot_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cnt_r      <= cnt_nxt;
    word_r     <= word_nxt;
    syn_r      <= syn_nxt;
    found_r    <= found_nxt;
    out_word_r <= out_word_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    word_nxt      = word_r;
    syn_nxt       = syn_r;
    found_nxt     = found_r;
    out_word_nxt  = out_word_r;
    out_valid_nxt = out_valid_r && out_stall;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          word_nxt  = in_received_word[WordW-1:0];
          syn_nxt   = '0;
          cnt_nxt   = '0;
          found_nxt = 1'b0;
          state_nxt = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        syn_nxt = unit_syn;
        if (cnt_r == CNT_LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_TRAP;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      ST_TRAP: begin
        // rotate right by one: next bit j is current bit j+1 (mod 23)
        word_nxt  = {fixed[0], fixed[WordW-1:1]};
        syn_nxt   = unit_syn;
        found_nxt = found_r || trap.hit;
        if (cnt_r == CNT_LAST) begin
          state_nxt = ST_HOLD;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      ST_HOLD: begin
        if (slot_free) begin
          out_word_nxt  = {^word_r, word_r};
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_stall         = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_decoded_word = out_word_r;

endmodule

>>> rtl/g24_checker.sv
// Port-level checker for the Golay (24,12) decoder, bound to the top level.
`include "golay_24_12_error_trap_decoder_unit_macros.svh"

module g24_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [23:0] out_decoded_word
);

  // a stalled result holds
  `G24_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_decoded_word))
  // overall parity bit matches the corrected bits
  `G24_ASSERT_IMP(a_parity, out_valid, out_decoded_word[23] == ^out_decoded_word[22:0])
  // decoder goes busy right after taking a word
  `G24_ASSERT_NXT(a_busy, in_valid && !in_stall, in_stall)
  // a new result only appears as the decoder leaves its busy phase
  `G24_ASSERT_IMP(a_done, $rose(out_valid), $past(in_stall) && !in_stall)

endmodule

bind golay_24_12_error_trap_decoder_unit g24_checker u_g24_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_decoded_word (out_decoded_word)
);
